// File: rtl/assert_macros.svh
// Assertion macros shared by the mutual exclusion node RTL.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RAMX_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ramx assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RAMX_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ramx assertion failed");

`endif

// File: rtl/ramx_pkg.sv
// Shared types and codes for the mutual exclusion node.
// No dependencies; used by every module of the block.
package ramx_pkg;

	localparam logic [2:0] CMD_LOCAL_REQ = 3'd0;
	localparam logic [2:0] CMD_PEER_REQ  = 3'd1;
	localparam logic [2:0] CMD_PEER_REP  = 3'd2;
	localparam logic [2:0] CMD_RELEASE   = 3'd3;
	localparam logic [2:0] CMD_DONE      = 3'd4;

	localparam logic [1:0] KIND_REPLY     = 2'd0;
	localparam logic [1:0] KIND_BROADCAST = 2'd1;
	localparam logic [1:0] KIND_GRANT     = 2'd2;

	localparam logic REG_NODE_ID    = 1'b0;
	localparam logic REG_NODE_COUNT = 1'b1;

	localparam int ID_W     = 5;
	localparam int QUEUE_D  = 2;
	localparam int QPTR_W   = 1;
	localparam int QCNT_W   = 2;

	typedef enum logic [2:0] {
		OP_LOCAL_REQ = 3'd0,
		OP_PEER_REQ  = 3'd1,
		OP_PEER_REP  = 3'd2,
		OP_RELEASE   = 3'd3,
		OP_DONE      = 3'd4
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [ID_W-1:0]  peer;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [ID_W-1:0]  dest;
		logic             last;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_GRANT = 3'b010,
		ST_WALK  = 3'b100
	} bst_t;

endpackage

// File: rtl/ramx_front.sv
// Input side: accepts stream transactions and turns them into queue entries.
// Depends on ramx_pkg; drops commands that cannot have any effect.
module ramx_front #(
	parameter int TIME_BITS = 16,
	parameter int MAX_NODES = 16,
	parameter int IN_W      = 24
) (
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [IN_W-1:0]         s_tdata,
	input  logic [2:0]              s_tuser,
	input  logic                    q_full,
	output logic                    push,
	output ramx_pkg::cmd_t          push_cmd,
	output logic [TIME_BITS-1:0]    push_ts
);

	logic [ramx_pkg::ID_W-1:0] peer;
	logic                      keep;
	ramx_pkg::op_t             op;

	assign peer     = s_tdata[ramx_pkg::ID_W-1:0];
	assign push_ts  = s_tdata[ramx_pkg::ID_W +: TIME_BITS];
	assign s_tready = !q_full;

	always_comb begin
		keep = 1'b1;
		op   = ramx_pkg::OP_DONE;
		unique case (s_tuser)
			ramx_pkg::CMD_LOCAL_REQ: op = ramx_pkg::OP_LOCAL_REQ;
			ramx_pkg::CMD_PEER_REQ: begin
				op   = ramx_pkg::OP_PEER_REQ;
				keep = (peer != '0) && (32'(peer) <= 32'(MAX_NODES));
			end
			ramx_pkg::CMD_PEER_REP: op = ramx_pkg::OP_PEER_REP;
			ramx_pkg::CMD_RELEASE:  op = ramx_pkg::OP_RELEASE;
			ramx_pkg::CMD_DONE:     op = ramx_pkg::OP_DONE;
			default:                keep = 1'b0;
		endcase
	end

	assign push          = s_tvalid && s_tready && keep;
	assign push_cmd.op   = op;
	assign push_cmd.peer = peer;

endmodule

// File: rtl/ramx_fifo.sv
// Two-entry queue between the input side and the execution side.
// Depends on ramx_pkg for its depth and pointer widths.
module ramx_fifo #(
	parameter int WIDTH = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0]             mem_q [ramx_pkg::QUEUE_D];
	logic [ramx_pkg::QPTR_W-1:0]  wr_q;
	logic [ramx_pkg::QPTR_W-1:0]  rd_q;
	logic [ramx_pkg::QCNT_W-1:0]  cnt_q;

	assign full  = (cnt_q == ramx_pkg::QCNT_W'(ramx_pkg::QUEUE_D));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

`include "assert_macros.svh"
	`RAMX_ASSERT(a_no_overflow, push, !full || pop)
	`RAMX_ASSERT(a_no_underflow, pop, !empty)

endmodule

// File: rtl/ramx_back.sv
// Execution side: holds the protocol state and configuration and drives results.
// Depends on ramx_pkg; takes entries from ramx_fifo and owns the output register.
module ramx_back #(
	parameter int MAX_NODES = 16,
	parameter int TIME_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic                      wr_index,
	input  logic [ramx_pkg::ID_W-1:0] wr_data,
	input  logic                      q_empty,
	input  ramx_pkg::cmd_t            q_cmd,
	input  logic [TIME_BITS-1:0]      q_ts,
	output logic                      pop,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output ramx_pkg::res_t            m_res
);

	localparam int CNT_W = $clog2(MAX_NODES);

	ramx_pkg::bst_t              state_q, state_d;
	logic [ramx_pkg::ID_W-1:0]   node_id_q;
	logic [ramx_pkg::ID_W-1:0]   node_count_q;
	logic                        requesting_q, requesting_d;
	logic [TIME_BITS-1:0]        own_time_q, own_time_d;
	logic [CNT_W-1:0]            count_q, count_d;
	logic [MAX_NODES-1:0]        map_q, map_d;
	logic                        done_q, done_d;
	logic                        out_valid_q;
	ramx_pkg::res_t              out_res_q;

	logic                        out_free;
	logic                        emit;
	ramx_pkg::res_t              res;
	logic [ramx_pkg::ID_W-1:0]   nc_clamped;
	logic [CNT_W-1:0]            need;
	logic [CNT_W-1:0]            cnt_inc;
	logic                        answer;
	logic [MAX_NODES-1:0]        low_bit;
	logic [MAX_NODES-1:0]        map_rest;
	logic [ramx_pkg::ID_W-1:0]   low_id;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_res    = out_res_q;

	always_comb begin
		if (32'(node_count_q) > 32'(MAX_NODES)) nc_clamped = ramx_pkg::ID_W'(MAX_NODES);
		else                                     nc_clamped = node_count_q;
		if (nc_clamped <= ramx_pkg::ID_W'(1)) need = '0;
		else                                  need = CNT_W'(nc_clamped - 1'b1);
	end

	assign cnt_inc = count_q + 1'b1;
	assign answer  = done_q || !requesting_q || (q_ts < own_time_q) ||
	                 ((q_ts == own_time_q) && (q_cmd.peer < node_id_q));

	// Lowest pending deferred peer: isolate the lowest set bit of the map.
	assign low_bit  = map_q & (~map_q + 1'b1);
	assign map_rest = map_q & ~low_bit;

	always_comb begin
		low_id = '0;
		for (int i = 0; i < MAX_NODES; i++) begin
			if (low_bit[i]) low_id = low_id | ramx_pkg::ID_W'(i + 1);
		end
	end

	always_comb begin
		state_d      = state_q;
		requesting_d = requesting_q;
		own_time_d   = own_time_q;
		count_d      = count_q;
		map_d        = map_q;
		done_d       = done_q;
		pop          = 1'b0;
		emit         = 1'b0;
		res          = '{kind: ramx_pkg::KIND_REPLY, dest: '0, last: 1'b1};
		unique case (state_q)
			ramx_pkg::ST_IDLE: begin
				if (!q_empty && out_free) begin
					pop = 1'b1;
					unique case (q_cmd.op)
						ramx_pkg::OP_LOCAL_REQ: begin
							requesting_d = 1'b1;
							own_time_d   = q_ts;
							count_d      = '0;
							emit         = 1'b1;
							res.kind     = ramx_pkg::KIND_BROADCAST;
							res.last     = (need != '0);
							if (need == '0) state_d = ramx_pkg::ST_GRANT;
						end
						ramx_pkg::OP_PEER_REQ: begin
							if (answer) begin
								emit     = 1'b1;
								res.dest = q_cmd.peer;
							end else begin
								map_d = map_q | (MAX_NODES'(1) << (q_cmd.peer - 1'b1));
							end
						end
						ramx_pkg::OP_PEER_REP: begin
							if (requesting_q && (count_q < need)) begin
								count_d = cnt_inc;
								if (cnt_inc == need) begin
									emit     = 1'b1;
									res.kind = ramx_pkg::KIND_GRANT;
								end
							end
						end
						ramx_pkg::OP_RELEASE: begin
							requesting_d = 1'b0;
							count_d      = '0;
							if (map_q != '0) state_d = ramx_pkg::ST_WALK;
						end
						ramx_pkg::OP_DONE: done_d = 1'b1;
						default: ;
					endcase
				end
			end
			ramx_pkg::ST_GRANT: begin
				if (out_free) begin
					emit     = 1'b1;
					res.kind = ramx_pkg::KIND_GRANT;
					state_d  = ramx_pkg::ST_IDLE;
				end
			end
			ramx_pkg::ST_WALK: begin
				if (out_free) begin
					emit     = 1'b1;
					res.dest = low_id;
					res.last = (map_rest == '0);
					map_d    = map_rest;
					if (map_rest == '0) state_d = ramx_pkg::ST_IDLE;
				end
			end
			default: state_d = ramx_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ramx_pkg::ST_IDLE;
			node_id_q    <= ramx_pkg::ID_W'(1);
			node_count_q <= ramx_pkg::ID_W'(2);
			requesting_q <= 1'b0;
			own_time_q   <= '0;
			count_q      <= '0;
			map_q        <= '0;
			done_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			requesting_q <= requesting_d;
			own_time_q   <= own_time_d;
			count_q      <= count_d;
			map_q        <= map_d;
			done_q       <= done_d;
			if (wr_en) begin
				if (wr_index == ramx_pkg::REG_NODE_ID) node_id_q    <= wr_data;
				else                                   node_count_q <= wr_data;
			end
			if (emit)          out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) out_res_q <= res;
	end

`include "assert_macros.svh"
	`RAMX_ASSERT(a_walk_has_work, state_q == ramx_pkg::ST_WALK, map_q != '0)
	`RAMX_ASSERT(a_pop_only_idle, pop, state_q == ramx_pkg::ST_IDLE)
	`RAMX_ASSERT_NXT(a_grant_returns, (state_q == ramx_pkg::ST_GRANT) && out_free,
		(state_q == ramx_pkg::ST_IDLE) && out_valid_q && out_res_q.last)

endmodule

// File: rtl/ricart_agrawala_mutex_node.sv
// Top level of one Ricart-Agrawala mutual exclusion node.
// Depends on ramx_pkg, ramx_front, ramx_fifo and ramx_back.
//
// Commands arrive on the s_ stream (s_tuser = command, s_tdata = peer id and
// timestamp); messages to send leave on the m_ stream (m_tuser = message kind,
// m_tdata = destination id, m_tlast = final message of one command).
// node_id and node_count are set through the wr_en/wr_index/wr_data port;
// the user must write them only while no command is in flight, as the block
// does not enforce it. A transaction enters a two-entry queue at the edge
// that accepts it; the execution side takes it once it is idle and the
// output register is free, and registers its first message into the output
// register that drives m_tvalid. Most commands are handled from the idle
// state; a local request that needs no replies sends a broadcast, then a
// grant; a release walks the deferred map, one reply per deferred peer.
// When m_tready is low the output register holds its message, the execution
// side waits, and the queue absorbs up to two more commands before s_tready
// drops. Reset clears all protocol state, empties the queue and sets
// node_id to 1 and node_count to 2.
module ricart_agrawala_mutex_node #(
	parameter int MAX_NODES = 16,
	parameter int TIME_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic                      wr_index,
	input  logic [ramx_pkg::ID_W-1:0] wr_data,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// peer_id [4:0], timestamp [TIME_BITS+4:5], zero padding above
	input  logic [((ramx_pkg::ID_W+TIME_BITS+7)/8)*8-1:0] s_tdata,
	// cmd [2:0]
	input  logic [2:0]                s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// dest_id [4:0], zero padding [7:5]
	output logic [7:0]                m_tdata,
	// kind [1:0]
	output logic [1:0]                m_tuser,
	output logic                      m_tlast
);

	localparam int IN_W = ((ramx_pkg::ID_W + TIME_BITS + 7) / 8) * 8;
	localparam int Q_W  = $bits(ramx_pkg::cmd_t) + TIME_BITS;

	logic                    push;
	ramx_pkg::cmd_t          push_cmd;
	logic [TIME_BITS-1:0]    push_ts;
	logic                    q_full;
	logic                    q_empty;
	logic                    pop;
	logic [Q_W-1:0]          q_rdata;
	ramx_pkg::cmd_t          q_cmd;
	logic [TIME_BITS-1:0]    q_ts;
	ramx_pkg::res_t          res;

	ramx_front #(
		.TIME_BITS (TIME_BITS),
		.MAX_NODES (MAX_NODES),
		.IN_W      (IN_W)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd),
		.push_ts  (push_ts)
	);

	ramx_fifo #(
		.WIDTH (Q_W)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({push_cmd, push_ts}),
		.pop    (pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign q_cmd = q_rdata[Q_W-1 -: $bits(ramx_pkg::cmd_t)];
	assign q_ts  = q_rdata[TIME_BITS-1:0];

	ramx_back #(
		.MAX_NODES (MAX_NODES),
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.q_empty  (q_empty),
		.q_cmd    (q_cmd),
		.q_ts     (q_ts),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_res    (res)
	);

	assign m_tdata = {3'b000, res.dest};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

endmodule
